// File: sv/radix_suffix_integer_parser_top_assert.svh
// Assertion macros for the radix suffix integer parser checker.
// Used by rsip_checker.sv; needs nothing else.
`ifndef RADIX_SUFFIX_INTEGER_PARSER_TOP_ASSERT_SVH
`define RADIX_SUFFIX_INTEGER_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define RSIP_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSIP_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rsip_pkg.sv
// Shared types and constants for the radix suffix integer parser.
// No dependencies.
`timescale 1ns / 1ps

package rsip_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int OUT_BITS      = 32;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [3:0] {
    CL_OCT,
    CL_DEC89,
    CL_HEXL,
    CL_BLANK,
    CL_PLUS,
    CL_MINUS,
    CL_SUFX,
    CL_SUFQ,
    CL_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } char_item_t;

  typedef struct packed {
    logic       valid;
    char_item_t item;
  } push_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_DIGITS,
    PH_TRAIL
  } scan_phase_t;

  typedef enum logic [1:0] {
    SUF_NONE,
    SUF_HEX,
    SUF_OCT
  } suffix_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

endpackage

// File: sv/rsip_if.sv
// Channel interfaces: character input and parse result output.
// Standalone; valid/ready handshake.
`timescale 1ns / 1ps

interface rsip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface rsip_out_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [1:0]  radix_kind;
  logic signed [31:0] int_value;
  modport source (output valid, parse_ok, radix_kind, int_value, input ready);
  modport sink   (input valid, parse_ok, radix_kind, int_value, output ready);
endinterface

// File: sv/rsip_front.sv
// Front end: accepts characters and classifies them for the queue.
// Depends on rsip_pkg and rsip_in_if.
`timescale 1ns / 1ps

module rsip_front (
  rsip_in_if.sink         chars,
  input  logic            queue_full,
  output rsip_pkg::push_t push
);

  rsip_pkg::char_class_t cls;
  logic [3:0]            digit;
  logic [7:0]            c;

  assign c = chars.char_code;

  always_comb begin
    digit = 4'd0;
    unique case (c) inside
      [8'h30:8'h37]: begin
        cls   = rsip_pkg::CL_OCT;
        digit = c[3:0];
      end
      8'h38, 8'h39: begin
        cls   = rsip_pkg::CL_DEC89;
        digit = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        cls   = rsip_pkg::CL_HEXL;
        digit = c[3:0] + 4'd9;
      end
      [8'h09:8'h0d], 8'h20: cls = rsip_pkg::CL_BLANK;
      8'h2b:                cls = rsip_pkg::CL_PLUS;
      8'h2d:                cls = rsip_pkg::CL_MINUS;
      8'h58, 8'h78:         cls = rsip_pkg::CL_SUFX;
      8'h51, 8'h71:         cls = rsip_pkg::CL_SUFQ;
      default:              cls = rsip_pkg::CL_OTHER;
    endcase
  end

  assign chars.ready     = !queue_full;
  assign push.valid      = chars.valid && !queue_full;
  assign push.item.cls   = cls;
  assign push.item.digit = digit;
  assign push.item.last  = chars.last_char;

endmodule

// File: sv/rsip_queue.sv
// Short queue of classified characters between front and back end.
// Depends on rsip_pkg.
`timescale 1ns / 1ps

module rsip_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  rsip_pkg::push_t      push,
  output logic                 full,
  output logic                 q_valid,
  output rsip_pkg::char_item_t q_item,
  input  logic                 pop
);

  localparam int DEPTH  = rsip_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rsip_pkg::char_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/rsip_back.sv
// Back end: scan state machine, parallel accumulators and result register.
// Depends on rsip_pkg and rsip_out_if.
`timescale 1ns / 1ps

module rsip_back #(
  parameter int WORD_BITS = rsip_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  rsip_pkg::char_item_t q_item,
  output logic                 pop,
  rsip_out_if.source           results
);

  localparam int OB = rsip_pkg::OUT_BITS;

  rsip_pkg::scan_phase_t phase, phase_next;
  rsip_pkg::suffix_t     suffix_kind, suffix_kind_next;
  logic                  negative_sign, negative_sign_next;
  logic [WORD_BITS-1:0]  decimal_accum, decimal_accum_next;
  logic [WORD_BITS-1:0]  hex_accum, hex_accum_next;
  logic [WORD_BITS-1:0]  octal_accum, octal_accum_next;
  logic                  only_decimal_digits, only_decimal_digits_next;
  logic                  only_octal_digits, only_octal_digits_next;
  logic                  digit_seen, digit_seen_next;
  logic                  format_error, format_error_next;

  logic                  out_valid;
  logic                  parse_ok, parse_ok_next;
  rsip_pkg::radix_t      radix_kind, radix_kind_next;
  logic [OB-1:0]         int_value, int_value_next;

  logic                  is_digit, is_blank, take;
  logic [WORD_BITS-1:0]  d_ext, hex_step, dec_step, oct_step;
  logic [WORD_BITS-1:0]  sel_val;
  logic [WORD_BITS+OB-1:0] val_ext;
  logic                  ok;
  logic                  fire, fire_last;

  // accumulators carry the sign already: a negative literal subtracts each digit
  assign d_ext    = {{(WORD_BITS-4){1'b0}}, q_item.digit};
  assign hex_step = negative_sign ? (hex_accum << 4) - d_ext : (hex_accum << 4) + d_ext;
  assign dec_step = negative_sign ? (decimal_accum << 3) + (decimal_accum << 1) - d_ext
                                  : (decimal_accum << 3) + (decimal_accum << 1) + d_ext;
  assign oct_step = negative_sign ? (octal_accum << 3) - d_ext : (octal_accum << 3) + d_ext;

  assign is_digit = (q_item.cls == rsip_pkg::CL_OCT) || (q_item.cls == rsip_pkg::CL_DEC89)
                 || (q_item.cls == rsip_pkg::CL_HEXL);
  assign is_blank = (q_item.cls == rsip_pkg::CL_BLANK);

  assign pop       = q_valid && (!q_item.last || !out_valid || results.ready);
  assign fire      = pop;
  assign fire_last = pop && q_item.last;

  always_comb begin
    phase_next        = phase;
    suffix_kind_next  = suffix_kind;
    negative_sign_next = negative_sign;
    format_error_next = format_error;
    take              = 1'b0;
    if (!format_error) begin
      unique case (phase)
        rsip_pkg::PH_LEAD: begin
          if (q_item.cls == rsip_pkg::CL_PLUS || q_item.cls == rsip_pkg::CL_MINUS) begin
            negative_sign_next = (q_item.cls == rsip_pkg::CL_MINUS);
            phase_next         = rsip_pkg::PH_SIGNED;
          end else if (is_digit) begin
            take       = 1'b1;
            phase_next = rsip_pkg::PH_DIGITS;
          end else if (!is_blank) begin
            format_error_next = 1'b1;
          end
        end
        rsip_pkg::PH_SIGNED, rsip_pkg::PH_DIGITS: begin
          if (is_digit) begin
            take       = 1'b1;
            phase_next = rsip_pkg::PH_DIGITS;
          end else if (phase == rsip_pkg::PH_DIGITS && q_item.cls == rsip_pkg::CL_SUFX) begin
            suffix_kind_next = rsip_pkg::SUF_HEX;
            phase_next       = rsip_pkg::PH_TRAIL;
          end else if (phase == rsip_pkg::PH_DIGITS && q_item.cls == rsip_pkg::CL_SUFQ) begin
            suffix_kind_next = rsip_pkg::SUF_OCT;
            phase_next       = rsip_pkg::PH_TRAIL;
          end else if (phase == rsip_pkg::PH_DIGITS && is_blank) begin
            phase_next = rsip_pkg::PH_TRAIL;
          end else begin
            format_error_next = 1'b1;
          end
        end
        rsip_pkg::PH_TRAIL: begin
          if (!is_blank) format_error_next = 1'b1;
        end
        default: format_error_next = 1'b1;
      endcase
    end

    hex_accum_next           = hex_accum;
    decimal_accum_next       = decimal_accum;
    octal_accum_next         = octal_accum;
    only_decimal_digits_next = only_decimal_digits;
    only_octal_digits_next   = only_octal_digits;
    digit_seen_next          = digit_seen;
    if (take) begin
      hex_accum_next  = hex_step;
      digit_seen_next = 1'b1;
      case (q_item.cls)
        rsip_pkg::CL_OCT: begin
          decimal_accum_next = dec_step;
          octal_accum_next   = oct_step;
        end
        rsip_pkg::CL_DEC89: begin
          decimal_accum_next     = dec_step;
          only_octal_digits_next = 1'b0;
        end
        default: begin
          only_decimal_digits_next = 1'b0;
          only_octal_digits_next   = 1'b0;
        end
      endcase
    end

    ok              = 1'b0;
    radix_kind_next = rsip_pkg::RADIX_DEC;
    sel_val         = '0;
    if (!format_error_next && digit_seen_next) begin
      unique case (suffix_kind_next)
        rsip_pkg::SUF_HEX: begin
          ok              = 1'b1;
          radix_kind_next = rsip_pkg::RADIX_HEX;
          sel_val         = hex_accum_next;
        end
        rsip_pkg::SUF_OCT: begin
          if (only_octal_digits_next) begin
            ok              = 1'b1;
            radix_kind_next = rsip_pkg::RADIX_OCT;
            sel_val         = octal_accum_next;
          end
        end
        default: begin
          if (only_decimal_digits_next) begin
            ok      = 1'b1;
            sel_val = decimal_accum_next;
          end
        end
      endcase
    end
    parse_ok_next  = ok;
    val_ext        = {{OB{1'b0}}, sel_val};
    int_value_next = val_ext[OB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || fire_last) begin
      phase               <= rsip_pkg::PH_LEAD;
      suffix_kind         <= rsip_pkg::SUF_NONE;
      negative_sign       <= 1'b0;
      decimal_accum       <= '0;
      hex_accum           <= '0;
      octal_accum         <= '0;
      only_decimal_digits <= 1'b1;
      only_octal_digits   <= 1'b1;
      digit_seen          <= 1'b0;
      format_error        <= 1'b0;
    end else if (fire) begin
      phase               <= phase_next;
      suffix_kind         <= suffix_kind_next;
      negative_sign       <= negative_sign_next;
      decimal_accum       <= decimal_accum_next;
      hex_accum           <= hex_accum_next;
      octal_accum         <= octal_accum_next;
      only_decimal_digits <= only_decimal_digits_next;
      only_octal_digits   <= only_octal_digits_next;
      digit_seen          <= digit_seen_next;
      format_error        <= format_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire_last || (out_valid && !results.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      parse_ok   <= parse_ok_next;
      radix_kind <= radix_kind_next;
      int_value  <= int_value_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.parse_ok   = parse_ok;
  assign results.radix_kind = radix_kind;
  assign results.int_value  = int_value;

endmodule

// File: sv/radix_suffix_integer_parser_top.sv
// Radix suffix integer parser: ASCII characters in, one parse result per string out.
// Channel chars (rsip_in_if.sink) carries char_code and last_char; channel results
// (rsip_out_if.source) carries parse_ok, radix_kind and int_value.
// Each transaction on chars is one character; the transaction with last_char set
// ends the string and produces exactly one transaction on results.
// Throughput: one character per cycle sustained while results is not stalled; the
// scan state machine and its decimal, hex and octal accumulators update once per
// popped queue entry. A final character is registered in the queue and then in the
// result register before its parse shows on results; it waits behind older entries.
// When results is stalled, the back end keeps taking non-final characters; a final
// character waits in the two-entry queue, and chars.ready drops once it is full.
// Reset (rst, synchronous, active high) empties the queue, drops results.valid and
// returns the scanner to the leading whitespace phase.
// Depends on rsip_pkg, rsip_if, rsip_front, rsip_queue and rsip_back.
`timescale 1ns / 1ps

module radix_suffix_integer_parser_top #(
  parameter int WORD_BITS = rsip_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rsip_in_if.sink     chars,
  rsip_out_if.source  results
);

  rsip_pkg::push_t      push;
  rsip_pkg::char_item_t q_item;
  logic                 queue_full;
  logic                 q_valid;
  logic                 pop;

  rsip_front u_front (
    .chars      (chars),
    .queue_full (queue_full),
    .push       (push)
  );

  rsip_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (queue_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop)
  );

  rsip_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .results (results)
  );

endmodule

// File: sv/rsip_checker.sv
// Port-level checks for the radix suffix integer parser, bound to the top level.
// Depends on radix_suffix_integer_parser_top_assert.svh.
`timescale 1ns / 1ps
`include "radix_suffix_integer_parser_top_assert.svh"

module rsip_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        parse_ok,
  input logic [1:0]  radix_kind,
  input logic [31:0] int_value
);

  `RSIP_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !out_valid, "result valid after reset")

  `RSIP_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(parse_ok) && $stable(radix_kind) && $stable(int_value), "stalled result changed")

  `RSIP_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !parse_ok, radix_kind == 2'd0 && int_value == 32'd0, "failed parse carries data")

  `RSIP_ASSERT_NOW(a_radix_code, clk, rst, out_valid, radix_kind != 2'd3, "unused radix code")

endmodule

bind radix_suffix_integer_parser_top rsip_checker u_rsip_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .parse_ok   (results.parse_ok),
  .radix_kind (results.radix_kind),
  .int_value  (results.int_value)
);

// File: test/radix_suffix_integer_parser_top_test.sv
// Self-checking testbench for radix_suffix_integer_parser_top: drives character strings
// with random idling and checks every parse result against an in-bench predictor.
// Depends on rsip_pkg, rsip_if and the parser RTL.
`timescale 1ns / 1ps

module radix_suffix_integer_parser_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_CHARS = 850;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP = 18;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_7     = "7";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_LQ    = "q";
  localparam logic [7:0] CH_UQ    = "Q";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  typedef struct packed {
    logic             ok;
    rsip_pkg::radix_t kind;
    logic [31:0]      value;
  } parse_result_t;

  class literal_scoreboard;
    parse_result_t         pending_results[$];
    int                    mismatches;
    rsip_pkg::scan_phase_t phase;
    rsip_pkg::suffix_t     suffix;
    logic                  negative;
    logic                  bad_format;
    logic                  saw_digit;
    logic                  decimal_only;
    logic                  octal_only;
    logic [31:0]           dec_acc;
    logic [31:0]           hex_acc;
    logic [31:0]           oct_acc;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase        = rsip_pkg::PH_LEAD;
      suffix       = rsip_pkg::SUF_NONE;
      negative     = 1'b0;
      bad_format   = 1'b0;
      saw_digit    = 1'b0;
      decimal_only = 1'b1;
      octal_only   = 1'b1;
      dec_acc      = '0;
      hex_acc      = '0;
      oct_acc      = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
    endfunction

    function void take_digit(logic [7:0] c, int hv);
      logic [31:0] d;
      d = 32'(hv);
      hex_acc = {hex_acc[27:0], 4'b0} + d;
      if (c >= CH_0 && c <= CH_9) begin
        dec_acc = dec_acc * 32'd10 + d;
        if (c <= CH_7) oct_acc = {oct_acc[28:0], 3'b0} + d;
        else octal_only = 1'b0;
      end else begin
        decimal_only = 1'b0;
        octal_only = 1'b0;
      end
      saw_digit = 1'b1;
    endfunction

    function void absorb(logic [7:0] c);
      int hv;
      hv = hex_val(c);
      if (bad_format) return;
      case (phase)
        rsip_pkg::PH_LEAD: begin
          if (is_blank(c)) return;
          if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            phase = rsip_pkg::PH_SIGNED;
          end else if (hv >= 0) begin
            take_digit(c, hv);
            phase = rsip_pkg::PH_DIGITS;
          end else begin
            bad_format = 1'b1;
          end
        end
        rsip_pkg::PH_SIGNED, rsip_pkg::PH_DIGITS: begin
          if (hv >= 0) begin
            take_digit(c, hv);
            phase = rsip_pkg::PH_DIGITS;
          end else if (phase == rsip_pkg::PH_DIGITS && (c == CH_LX || c == CH_UX)) begin
            suffix = rsip_pkg::SUF_HEX;
            phase = rsip_pkg::PH_TRAIL;
          end else if (phase == rsip_pkg::PH_DIGITS && (c == CH_LQ || c == CH_UQ)) begin
            suffix = rsip_pkg::SUF_OCT;
            phase = rsip_pkg::PH_TRAIL;
          end else if (phase == rsip_pkg::PH_DIGITS && is_blank(c)) begin
            phase = rsip_pkg::PH_TRAIL;
          end else begin
            bad_format = 1'b1;
          end
        end
        default: begin
          if (!is_blank(c)) bad_format = 1'b1;
        end
      endcase
    endfunction

    // one accepted character; the final one of a string queues the expected parse
    function void note_char(logic [7:0] c, logic is_last);
      parse_result_t r;
      absorb(c);
      if (!is_last) return;
      r.ok = 1'b0;
      r.kind = rsip_pkg::RADIX_DEC;
      r.value = '0;
      if (!bad_format && saw_digit) begin
        case (suffix)
          rsip_pkg::SUF_HEX: begin
            r.ok = 1'b1;
            r.kind = rsip_pkg::RADIX_HEX;
            r.value = hex_acc;
          end
          rsip_pkg::SUF_OCT: begin
            if (octal_only) begin
              r.ok = 1'b1;
              r.kind = rsip_pkg::RADIX_OCT;
              r.value = oct_acc;
            end
          end
          default: begin
            if (decimal_only) begin
              r.ok = 1'b1;
              r.value = dec_acc;
            end
          end
        endcase
      end
      if (r.ok && negative) r.value = 32'd0 - r.value;
      pending_results.push_back(r);
      clear();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic ok, logic [1:0] kind, logic [31:0] value);
      parse_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result ok=%0b radix=%0d value=%h",
                                  ok, kind, value));
        return;
      end
      want = pending_results.pop_front();
      if (ok !== want.ok)
        report_mismatch($sformatf("parse_ok got %b want %b", ok, want.ok));
      if (kind !== 2'(want.kind))
        report_mismatch($sformatf("radix_kind got %0d want %0d", kind, want.kind));
      if (value !== want.value)
        report_mismatch($sformatf("int_value got %h want %h", value, want.value));
    endtask
  endclass

  logic clk;
  logic rst;

  rsip_in_if  chars_if ();
  rsip_out_if results_if ();

  radix_suffix_integer_parser_top u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  literal_scoreboard sb;
  logic [7:0]  line_buf[$];
  int          chars_sent;
  int          in_gap_max;
  int          out_gap_max;
  int          stall_left;
  int          cycle_count;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("radix_suffix_integer_parser_top_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_left = 0;
    end else if (results_if.valid && results_if.ready) begin
      sb.check_result(results_if.parse_ok, results_if.radix_kind, results_if.int_value);
      if ($urandom_range(0, 11) == 0) out_gap_max = $urandom_range(0, 1) ? MAX_GAP : 0;
      stall_left = $urandom_range(0, out_gap_max);
      results_if.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      results_if.ready <= (stall_left == 0);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  task automatic send_char(logic [7:0] c, logic is_last);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.last_char <= is_last;
    do @(posedge clk); while (!chars_if.ready);
    sb.note_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    line_buf = {};
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s.getc(i));
    send_line();
  endtask

  function automatic logic [7:0] rand_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  // mostly well-formed random literals; some have one byte clobbered or are random bytes
  task automatic build_random_line();
    int unsigned form;
    int unsigned n;
    int unsigned v;
    line_buf = {};
    repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
    case ($urandom_range(0, 3))
      1: line_buf.push_back(CH_PLUS);
      2: line_buf.push_back(CH_MINUS);
      default: ;
    endcase
    form = $urandom_range(0, 2);
    n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    repeat (n) begin
      case (form)
        0: line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
        1: begin
          v = $urandom_range(0, 21);
          if (v < 10) line_buf.push_back(8'(CH_0 + v));
          else if (v < 16) line_buf.push_back(8'(CH_LA + v - 10));
          else line_buf.push_back(8'(CH_UA + v - 16));
        end
        default: begin
          if ($urandom_range(0, 19) == 0) line_buf.push_back(8'(CH_0 + $urandom_range(8, 9)));
          else line_buf.push_back(8'(CH_0 + $urandom_range(0, 7)));
        end
      endcase
    end
    if (form == 1) line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    if (form == 2) line_buf.push_back($urandom_range(0, 1) ? CH_LQ : CH_UQ);
    repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
    if ($urandom_range(0, 4) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0) begin
      line_buf = {};
      repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb = new();
    chars_sent = 0;
    cycle_count = 0;
    in_gap_max = 0;
    out_gap_max = MAX_GAP;
    stall_left = 0;
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.char_code = '0;
    chars_if.last_char = 1'b0;
    results_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text(" ");
    send_text("-");
    send_text("+ 5");
    send_text("a");
    send_text("8q");
    send_text("x");
    send_text("1xq");
    send_text("-7Fx");
    send_text("+17q");
    send_text("09\t");

    while (chars_sent < TARGET_CHARS) begin
      if ($urandom_range(0, 7) == 0) in_gap_max = $urandom_range(0, 1) ? MAX_GAP : 0;
      build_random_line();
      send_line();
    end
    chars_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("radix_suffix_integer_parser_top_test: clean");
    else
      $display("radix_suffix_integer_parser_top_test: errors");
    $finish;
  end

endmodule
